/* design/hid_usage_index_lookup_defines.svh */
// Assertion macros shared by the usage index lookup RTL.
`ifndef HID_USAGE_INDEX_LOOKUP_DEFINES_SVH
`define HID_USAGE_INDEX_LOOKUP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and held off during reset.
`define HUL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and held off during reset.
`define HUL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hul_pkg.sv */
// Types and constants of the usage index lookup.
package hul_pkg;

  // Word layout of the input stream, lowest bit first.
  localparam int unsigned IN_TDATA_W   = 128;
  localparam int unsigned SLOT_LSB     = 0;
  localparam int unsigned IS_RANGE_BIT = 8;
  localparam int unsigned PAGE_LSB     = 9;
  localparam int unsigned USAGE_LSB    = 25;
  localparam int unsigned MIN_LSB      = 41;
  localparam int unsigned MAX_LSB      = 57;
  localparam int unsigned FIRST_LSB    = 73;
  localparam int unsigned COUNT_LSB    = 81;
  localparam int unsigned INDEX_LSB    = 90;

  // Word layout of the output stream.
  localparam int unsigned OUT_TDATA_W  = 32;

  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned SIZE_W  = 17;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUT_FOUND    = 2'd0,
    OUT_PAST_END = 2'd1,
    OUT_EMPTY    = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_SIZE,
    ST_CMP
  } state_e;

  // One table entry.
  typedef struct packed {
    logic        is_range;
    logic [15:0] page;
    logic [15:0] usage;
    logic [15:0] rmin;
    logic [15:0] rmax;
  } entry_t;

endpackage

/* design/hul_table.sv */
// Usage entry table: one write port, one read port with registered data.
module hul_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr_i,
  input  hul_pkg::entry_t                wdata_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr_i,
  output hul_pkg::entry_t                rdata_o
);

  hul_pkg::entry_t mem_q [TABLE_DEPTH];
  hul_pkg::entry_t rdata_q;

  // Write one entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry every cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hid_usage_index_lookup.sv */
// Top level of the usage index lookup: table, walk sequencer and result register.
`include "hid_usage_index_lookup_defines.svh"

// A load word writes one table entry, then the block returns to idle.
// A lookup word walks the table from first_slot, one entry at a time: the
// SIZE state reads the entry and forms its size, the CMP state uses the
// shared 33-bit subtractor that tests the index against the size and takes
// the size off. When TABLE_DEPTH is below 256 a slot at or above the depth
// is first brought into range by repeated subtraction of the depth, one
// subtraction per cycle. The result sits in an output register, so the
// block takes the next word while it waits; a new result stalls the walk
// only while the previous one has not been taken. The table holds whatever
// was last loaded; reading a slot never loaded gives undefined data.
module hid_usage_index_lookup #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: entry_slot[7:0], entry_is_range[8], entry_page[24:9],
  // entry_usage[40:25], entry_range_min[56:41], entry_range_max[72:57],
  // first_slot[80:73], item_count[89:81], usage_index[121:90], zero fill
  input  logic [127:0] s_axis_tdata_i,
  // tuser: operation[0]
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: usage_page[15:0], usage_value[31:16]
  output logic [31:0]  m_axis_tdata_o,
  // tuser: outcome[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [12:0] DEPTH_L = 13'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  hul_pkg::state_e   state_q, state_d;
  hul_pkg::op_e      op_q;
  logic [7:0]        red_q;
  hul_pkg::entry_t   load_q;
  logic [8:0]        count_q;
  logic [31:0]       idx_q;
  logic [AW-1:0]     slot_q;
  hul_pkg::entry_t   cur_q;
  logic [16:0]       size_q;

  logic              m_valid_q;
  logic [15:0]       res_page_q;
  logic [15:0]       res_value_q;
  hul_pkg::outcome_e res_code_q;

  hul_pkg::entry_t   rdata;
  logic [AW+7:0]     red_ext;
  logic [AW-1:0]     red_slot;
  logic              red_high;
  logic              accept;
  logic              out_free;
  logic [32:0]       diff;
  logic              hit;
  logic [16:0]       span;
  logic [AW-1:0]     slot_inc;

  // Control decoded from the state.
  logic              mem_we;
  logic              res_load;
  hul_pkg::outcome_e res_code;
  logic [15:0]       res_value;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Bring the slot into table range.
  assign red_high = {5'd0, red_q} >= DEPTH_L;
  assign red_ext  = {{AW{1'b0}}, red_q};
  assign red_slot = red_ext[AW-1:0];

  // Shared subtractor: index against the size of the current entry.
  assign diff = {1'b0, idx_q} - {16'd0, size_q};
  assign hit  = diff[32];

  // Size of the entry just read: span plus one for a range.
  assign span = (rdata.rmax >= rdata.rmin) ? ({1'b0, rdata.rmax} - {1'b0, rdata.rmin})
                                           : ({1'b0, rdata.rmin} - {1'b0, rdata.rmax});

  assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);

  hul_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(red_slot),
    .wdata_i(load_q),
    .raddr_i(slot_q),
    .rdata_o(rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hul_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = hul_pkg::ST_REDUCE;
        end
      end
      hul_pkg::ST_REDUCE: begin
        if (red_high) begin
          state_d = hul_pkg::ST_REDUCE;
        end else if (op_q == hul_pkg::OP_LOAD) begin
          state_d = hul_pkg::ST_IDLE;
        end else if (count_q == '0) begin
          if (out_free) begin
            state_d = hul_pkg::ST_IDLE;
          end
        end else begin
          state_d = hul_pkg::ST_FETCH;
        end
      end
      hul_pkg::ST_FETCH: state_d = hul_pkg::ST_SIZE;
      hul_pkg::ST_SIZE:  state_d = hul_pkg::ST_CMP;
      hul_pkg::ST_CMP: begin
        if (hit || count_q == 9'd1) begin
          if (out_free) begin
            state_d = hul_pkg::ST_IDLE;
          end
        end else begin
          state_d = hul_pkg::ST_SIZE;
        end
      end
      default: state_d = hul_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    res_load        = 1'b0;
    res_code        = hul_pkg::OUT_FOUND;
    res_value       = cur_q.usage;
    case (state_q)
      hul_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      hul_pkg::ST_REDUCE: begin
        if (!red_high && op_q == hul_pkg::OP_LOAD) begin
          mem_we = 1'b1;
        end else if (!red_high && count_q == '0) begin
          res_load  = out_free;
          res_code  = hul_pkg::OUT_EMPTY;
          res_value = '0;
        end
      end
      hul_pkg::ST_CMP: begin
        if (hit) begin
          res_load  = out_free;
          res_code  = hul_pkg::OUT_FOUND;
          res_value = cur_q.is_range ? (cur_q.rmin + idx_q[15:0]) : cur_q.usage;
        end else if (count_q == 9'd1) begin
          res_load  = out_free;
          res_code  = hul_pkg::OUT_PAST_END;
          res_value = cur_q.is_range ? cur_q.rmax : cur_q.usage;
        end
      end
      default: ;
    endcase
  end

  // Advance the state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hul_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the word and run the walk datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q            <= hul_pkg::op_e'(s_axis_tuser_i);
      red_q           <= (s_axis_tuser_i == hul_pkg::OP_LOAD)
                         ? s_axis_tdata_i[hul_pkg::SLOT_LSB +: 8]
                         : s_axis_tdata_i[hul_pkg::FIRST_LSB +: 8];
      load_q.is_range <= s_axis_tdata_i[hul_pkg::IS_RANGE_BIT];
      load_q.page     <= s_axis_tdata_i[hul_pkg::PAGE_LSB +: 16];
      load_q.usage    <= s_axis_tdata_i[hul_pkg::USAGE_LSB +: 16];
      load_q.rmin     <= s_axis_tdata_i[hul_pkg::MIN_LSB +: 16];
      load_q.rmax     <= s_axis_tdata_i[hul_pkg::MAX_LSB +: 16];
      count_q         <= s_axis_tdata_i[hul_pkg::COUNT_LSB +: 9];
      idx_q           <= s_axis_tdata_i[hul_pkg::INDEX_LSB +: 32];
    end else begin
      case (state_q)
        hul_pkg::ST_REDUCE: begin
          if (red_high) begin
            red_q <= red_q - DEPTH_L[7:0];
          end else begin
            slot_q <= red_slot;
          end
        end
        hul_pkg::ST_SIZE: begin
          cur_q  <= rdata;
          size_q <= rdata.is_range ? span + 17'd1 : 17'd1;
          slot_q <= slot_inc;
        end
        hul_pkg::ST_CMP: begin
          if (!hit && count_q != 9'd1) begin
            idx_q   <= diff[31:0];
            count_q <= count_q - 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_page_q  <= (res_code == hul_pkg::OUT_EMPTY) ? 16'd0 : cur_q.page;
      res_value_q <= res_value;
      res_code_q  <= res_code;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {res_value_q, res_page_q};
  assign m_axis_tuser_o  = res_code_q;

  `HUL_ASSERT_IMP(a_walk_has_entries,
    (state_q == hul_pkg::ST_FETCH || state_q == hul_pkg::ST_SIZE ||
     state_q == hul_pkg::ST_CMP), count_q != '0,
    "walk running with no entries left")
  `HUL_ASSERT_IMP(a_size_nonzero, state_q == hul_pkg::ST_CMP, size_q != '0,
    "entry size is zero during compare")
  `HUL_ASSERT_NXT(a_hit_gives_found, (state_q == hul_pkg::ST_CMP && hit && out_free),
    (m_axis_tvalid_o && m_axis_tuser_o == hul_pkg::OUT_FOUND && state_q == hul_pkg::ST_IDLE),
    "index hit did not produce a found result")

endmodule

/* tb/hid_usage_index_lookup_test.sv */
// Self-checking testbench of the usage index lookup: directed table, then random words.
module hid_usage_index_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_IDLE    = 13;

  // One input word, unpacked into its fields.
  typedef struct packed {
    hul_pkg::op_e    op;
    logic [7:0]      slot;
    hul_pkg::entry_t ent;
    logic [7:0]      first;
    logic [8:0]      count;
    logic [31:0]     index;
  } stim_word_t;

  typedef struct packed {
    logic [15:0]       page;
    logic [15:0]       value;
    hul_pkg::outcome_e outcome;
  } usage_result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    stim_word_t    word;
    logic          typed;
    usage_result_t want;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;

  hul_pkg::entry_t usage_table [TABLE_DEPTH];
  usage_result_t   expected_usages [$];
  dir_row_t        dir_rows [$];
  int unsigned     fail_count = 0;
  bit              tx_no_idle = 1'b0;
  bit              long_hold_req = 1'b0;

  hid_usage_index_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Walk the table from first_slot and find the entry that holds the index.
  function automatic usage_result_t resolve_usage(input stim_word_t w);
    usage_result_t   r;
    hul_pkg::entry_t e;
    logic [7:0]      slot;
    int unsigned     remaining;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     span;
    r.page    = '0;
    r.value   = '0;
    r.outcome = hul_pkg::OUT_EMPTY;
    e         = '0;
    if (w.count == 0) return r;
    // The slot wraps at 256, which is the table depth here.
    slot      = w.first;
    remaining = w.index;
    for (int unsigned n = 0; n < w.count; n++) begin
      e    = usage_table[slot];
      slot = slot + 8'd1;
      if (e.is_range) begin
        lo   = 32'(e.rmin);
        hi   = 32'(e.rmax);
        span = (hi >= lo ? hi - lo : lo - hi) + 1;
        if (remaining < span) begin
          r.page    = e.page;
          r.value   = 16'(lo + remaining);
          r.outcome = hul_pkg::OUT_FOUND;
          return r;
        end
        remaining -= span;
      end else begin
        if (remaining == 0) begin
          r.page    = e.page;
          r.value   = e.usage;
          r.outcome = hul_pkg::OUT_FOUND;
          return r;
        end
        remaining -= 1;
      end
    end
    // Ran off the end: give the last entry walked.
    r.page    = e.page;
    r.value   = e.is_range ? e.rmax : e.usage;
    r.outcome = hul_pkg::OUT_PAST_END;
    return r;
  endfunction

  // Build a load word; the lookup fields carry random filler.
  function automatic stim_word_t load_word(input logic [7:0] slot, input logic is_range,
                                           input logic [15:0] page, input logic [15:0] usage,
                                           input logic [15:0] rmin, input logic [15:0] rmax);
    stim_word_t w;
    w.op           = hul_pkg::OP_LOAD;
    w.slot         = slot;
    w.ent.is_range = is_range;
    w.ent.page     = page;
    w.ent.usage    = usage;
    w.ent.rmin     = rmin;
    w.ent.rmax     = rmax;
    w.first        = 8'($urandom);
    w.count        = 9'($urandom);
    w.index        = $urandom;
    return w;
  endfunction

  // Build a lookup word; the load fields carry random filler.
  function automatic stim_word_t lookup_word(input logic [7:0] first, input logic [8:0] count,
                                             input logic [31:0] index);
    stim_word_t w;
    w.op    = hul_pkg::OP_LOOKUP;
    w.slot  = 8'($urandom);
    w.ent   = hul_pkg::entry_t'(65'({$urandom, $urandom, $urandom}));
    w.first = first;
    w.count = count;
    w.index = index;
    return w;
  endfunction

  // Random entry: mostly narrow ranges, some reversed, some of random width.
  function automatic stim_word_t random_load(input logic [7:0] slot);
    logic [15:0] rmin;
    logic [15:0] rmax;
    rmin = 16'($urandom);
    case ($urandom_range(0, 3))
      0, 1:    rmax = 16'(rmin + $urandom_range(0, 15));
      2:       rmax = 16'(rmin - $urandom_range(1, 15));
      default: rmax = 16'($urandom);
    endcase
    return load_word(slot, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), rmin, rmax);
  endfunction

  // Random lookup: mostly short walks, a few up to the table depth.
  function automatic stim_word_t random_lookup();
    int unsigned pick;
    logic [8:0]  count;
    logic [31:0] index;
    pick = $urandom_range(0, 99);
    if (pick < 80)      count = 9'($urandom_range(0, 6));
    else if (pick < 95) count = 9'($urandom_range(7, 40));
    else                count = 9'($urandom_range(200, 256));
    case ($urandom_range(0, 4))
      0:       index = $urandom_range(0, 8);
      1:       index = $urandom_range(0, 40);
      2:       index = $urandom_range(0, 70000);
      3:       index = $urandom_range(0, 300000);
      default: index = $urandom;
    endcase
    return lookup_word(8'($urandom), count, index);
  endfunction

  // Offer one word, update the table or queue the expected result, then maybe idle.
  task automatic offer_word(input stim_word_t w, input logic typed, input usage_result_t want);
    logic [127:0] bits;
    int unsigned  gap;
    bits = '0;
    bits[hul_pkg::SLOT_LSB +: hul_pkg::SLOT_W]   = w.slot;
    bits[hul_pkg::IS_RANGE_BIT]                  = w.ent.is_range;
    bits[hul_pkg::PAGE_LSB +: 16]                = w.ent.page;
    bits[hul_pkg::USAGE_LSB +: 16]               = w.ent.usage;
    bits[hul_pkg::MIN_LSB +: 16]                 = w.ent.rmin;
    bits[hul_pkg::MAX_LSB +: 16]                 = w.ent.rmax;
    bits[hul_pkg::FIRST_LSB +: hul_pkg::SLOT_W]  = w.first;
    bits[hul_pkg::COUNT_LSB +: hul_pkg::COUNT_W] = w.count;
    bits[hul_pkg::INDEX_LSB +: hul_pkg::INDEX_W] = w.index;
    s_axis_tdata  <= bits;
    s_axis_tuser  <= w.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (w.op == hul_pkg::OP_LOAD) begin
      usage_table[w.slot] = w.ent;
    end else begin
      expected_usages.push_back(typed ? want : resolve_usage(w));
    end
    gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and hold until every expected result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_usages.size() != 0);
  endtask

  // Receiver: random hold-offs, one long hold on request, check each word.
  initial begin
    int unsigned   stall;
    int unsigned   rx_seen;
    usage_result_t want;
    rx_seen = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if ((rx_seen / 40) % 3 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rx_seen++;
      if (expected_usages.size() == 0) begin
        $error("unexpected result word: tdata=%h tuser=%0d", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_usages.pop_front();
        if (m_axis_tdata[15:0] !== want.page) begin
          $error("usage_page: expected %h, got %h", want.page, m_axis_tdata[15:0]);
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== want.value) begin
          $error("usage_value: expected %h, got %h", want.value, m_axis_tdata[31:16]);
          fail_count++;
        end
        if (m_axis_tuser !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed table, table fill, back pressure, then mixed traffic.
  initial begin
    dir_rows.push_back(dir_row_t'{load_word(8'd0, 1'b0, 16'h0001, 16'h0030, 16'hA5A5,
                                            16'h5A5A), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{load_word(8'd1, 1'b1, 16'h0009, 16'h7777, 16'h0001,
                                            16'h0008), 1'b0, '0});
    // Reversed range that wraps past the top of the usage space.
    dir_rows.push_back(dir_row_t'{load_word(8'd2, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFE,
                                            16'h0002), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{load_word(8'd255, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000,
                                            16'h0000), 1'b0, '0});
    // Full-width range: 65536 usages.
    dir_rows.push_back(dir_row_t'{load_word(8'd254, 1'b1, 16'h0000, 16'hFFFF, 16'h0000,
                                            16'hFFFF), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd255, 9'd0, 32'hFFFF_FFFF), 1'b1,
                                  usage_result_t'{16'h0000, 16'h0000, hul_pkg::OUT_EMPTY}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd1, 32'd0), 1'b1,
                                  usage_result_t'{16'h0001, 16'h0030, hul_pkg::OUT_FOUND}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd2, 32'd1), 1'b1,
                                  usage_result_t'{16'h0009, 16'h0001, hul_pkg::OUT_FOUND}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd2, 32'd8), 1'b1,
                                  usage_result_t'{16'h0009, 16'h0008, hul_pkg::OUT_FOUND}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd2, 32'd9), 1'b1,
                                  usage_result_t'{16'h0009, 16'h0008, hul_pkg::OUT_PAST_END}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd2, 9'd1, 32'd3), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd2, 9'd1, 32'hFFFF_FFFF), 1'b1,
                                  usage_result_t'{16'hFFFF, 16'h0002, hul_pkg::OUT_PAST_END}});
    // Walks that wrap from the top slot back to slot 0.
    dir_rows.push_back(dir_row_t'{lookup_word(8'd254, 9'd3, 32'd65536), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd254, 9'd3, 32'd65537), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd255, 9'd2, 32'd0), 1'b1,
                                  usage_result_t'{16'hFFFF, 16'hFFFF, hul_pkg::OUT_FOUND}});
    dir_rows.push_back(dir_row_t'{load_word(8'd3, 1'b1, 16'h1234, 16'h0000, 16'h0005,
                                            16'h0005), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd3, 9'd1, 32'd0), 1'b1,
                                  usage_result_t'{16'h1234, 16'h0005, hul_pkg::OUT_FOUND}});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd3, 9'd1, 32'd1), 1'b1,
                                  usage_result_t'{16'h1234, 16'h0005, hul_pkg::OUT_PAST_END}});
    // Overwrite a range with a single usage.
    dir_rows.push_back(dir_row_t'{load_word(8'd1, 1'b0, 16'h8000, 16'h4242, 16'h0001,
                                            16'h0008), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd3, 32'd1), 1'b0, '0});
    dir_rows.push_back(dir_row_t'{lookup_word(8'd0, 9'd4, 32'd9), 1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    // Fill every slot so that no random walk reads an unwritten entry.
    for (int unsigned s = 0; s < TABLE_DEPTH; s++) offer_word(random_load(8'(s)), 1'b0, '0);

    // Hold the receiver off while lookups keep coming back to back.
    drain();
    long_hold_req = 1'b1;
    tx_no_idle    = 1'b1;
    repeat (30) offer_word(random_lookup(), 1'b0, '0);
    drain();

    // Mixed traffic in segments, every third one without sender gaps.
    for (int unsigned seg = 0; seg < 6; seg++) begin
      tx_no_idle = (seg % 3 == 1);
      repeat (57) begin
        if ($urandom_range(0, 9) < 3) offer_word(random_load(8'($urandom)), 1'b0, '0);
        else offer_word(random_lookup(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("hid_usage_index_lookup regression: pass");
    end else begin
      $display("hid_usage_index_lookup regression: fail");
    end
    $finish;
  end

  // Abort a run that hangs.
  initial begin
    #8_000_000;
    $display("hid_usage_index_lookup regression: fail");
    $finish;
  end

endmodule
